### rtl/core/triangle_face_normal_unit_defines.svh
// Assertion macros shared by the triangle face normal RTL.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define TFN_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tfn assertion failed");
// Check a property on every rising clock edge, reset included.
`define TFN_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tfn assertion failed");
`else
`define TFN_ASSERT(label, clk, rst, prop)
`define TFN_ASSERT_NORST(label, clk, prop)
`endif

`endif

### rtl/core/tfn_pkg.sv
`timescale 1ns / 1ps
package tfn_pkg;

   localparam int COORD_WIDTH_DEF      = 24;
   localparam int NORMAL_FRAC_BITS_DEF = 14;
   localparam int LANES                = 3;

   // Flags that ride along with each triangle through the pipe.
   typedef struct packed {
      logic             degenerate;
      logic [LANES-1:0] neg;
   } side_type;

endpackage

### rtl/core/tfn_if.sv
`timescale 1ns / 1ps
interface tfn_req_if import tfn_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] p0_x;
   logic signed [COORD_WIDTH-1:0] p0_y;
   logic signed [COORD_WIDTH-1:0] p0_z;
   logic signed [COORD_WIDTH-1:0] p1_x;
   logic signed [COORD_WIDTH-1:0] p1_y;
   logic signed [COORD_WIDTH-1:0] p1_z;
   logic signed [COORD_WIDTH-1:0] p2_x;
   logic signed [COORD_WIDTH-1:0] p2_y;
   logic signed [COORD_WIDTH-1:0] p2_z;

   modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                   input ready);
   modport sink (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                 output ready);
endinterface

interface tfn_rsp_if import tfn_pkg::*; #(
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) ();
   logic                               valid;
   logic                               ready;
   logic signed [NORMAL_FRAC_BITS+1:0] normal_x;
   logic signed [NORMAL_FRAC_BITS+1:0] normal_y;
   logic signed [NORMAL_FRAC_BITS+1:0] normal_z;
   logic                               degenerate;

   modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
   modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

### rtl/core/tfn_cross.sv
`timescale 1ns / 1ps
`include "triangle_face_normal_unit_defines.svh"
module tfn_cross import tfn_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic signed [COORD_WIDTH-1:0]     p0_x,
   input  logic signed [COORD_WIDTH-1:0]     p0_y,
   input  logic signed [COORD_WIDTH-1:0]     p0_z,
   input  logic signed [COORD_WIDTH-1:0]     p1_x,
   input  logic signed [COORD_WIDTH-1:0]     p1_y,
   input  logic signed [COORD_WIDTH-1:0]     p1_z,
   input  logic signed [COORD_WIDTH-1:0]     p2_x,
   input  logic signed [COORD_WIDTH-1:0]     p2_y,
   input  logic signed [COORD_WIDTH-1:0]     p2_z,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [4*COORD_WIDTH+3:0]          s_out,
   output logic [LANES-1:0][4*COORD_WIDTH+3:0] c2_out,
   output side_type                          side_out
);

   localparam int W    = COORD_WIDTH;
   localparam int EW   = W + 1;
   localparam int PW   = 2 * EW;
   localparam int CX   = PW + 1;
   localparam int CM   = 2 * W + 1;
   localparam int LO   = (CM + 1) / 2;
   localparam int HI   = CM - LO;
   localparam int SW   = 2 * CM + 2;
   localparam int NSTG = 6;

   logic [NSTG-1:0] vld_ff, vld_in, ld;
   logic [NSTG:0]   rdy;

   logic signed [W-1:0]  pa0 [LANES];
   logic signed [W-1:0]  pa1 [LANES];
   logic signed [W-1:0]  pa2 [LANES];

   logic signed [EW-1:0] e1_ff [LANES];
   logic signed [EW-1:0] e2_ff [LANES];
   logic signed [EW-1:0] e1_in [LANES];
   logic signed [EW-1:0] e2_in [LANES];
   logic signed [PW-1:0] pa_ff [LANES];
   logic signed [PW-1:0] pb_ff [LANES];
   logic signed [PW-1:0] pa_in [LANES];
   logic signed [PW-1:0] pb_in [LANES];
   logic [CM-1:0]        mag_ff [LANES];
   logic [CM-1:0]        mag_in [LANES];
   logic [2*HI-1:0]      hh_ff [LANES];
   logic [2*HI-1:0]      hh_in [LANES];
   logic [CM-1:0]        hl_ff [LANES];
   logic [CM-1:0]        hl_in [LANES];
   logic [2*LO-1:0]      ll_ff [LANES];
   logic [2*LO-1:0]      ll_in [LANES];
   logic [SW-1:0]        sq_ff [LANES];
   logic [SW-1:0]        sq_in [LANES];
   logic [LANES-1:0][SW-1:0] c2_ff;
   logic [SW-1:0]        s_ff, s_in;
   side_type             sd2_ff, sd2_in, sd3_ff, sd4_ff, sd5_ff;

   logic signed [CX-1:0] cd;
   logic signed [CX-1:0] cabs;
   logic [HI-1:0]        hpart;
   logic [LO-1:0]        lpart;

   // handshake: each stage takes new data when empty or when it drains
   always_comb begin
      rdy[NSTG] = dn_ready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      ld[0]     = rdy[0] && up_valid;
      vld_in[0] = rdy[0] ? up_valid : vld_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         ld[i]     = rdy[i] && vld_ff[i-1];
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      pa0[0] = p0_x; pa0[1] = p0_y; pa0[2] = p0_z;
      pa1[0] = p1_x; pa1[1] = p1_y; pa1[2] = p1_z;
      pa2[0] = p2_x; pa2[1] = p2_y; pa2[2] = p2_z;
      for (int k = 0; k < LANES; k++) begin
         e1_in[k] = $signed({pa2[k][W-1], pa2[k]}) - $signed({pa1[k][W-1], pa1[k]});
         e2_in[k] = $signed({pa0[k][W-1], pa0[k]}) - $signed({pa1[k][W-1], pa1[k]});
      end
   end

   // cross product terms
   always_comb begin
      pa_in[0] = e1_ff[1] * e2_ff[2];
      pb_in[0] = e1_ff[2] * e2_ff[1];
      pa_in[1] = e1_ff[2] * e2_ff[0];
      pb_in[1] = e1_ff[0] * e2_ff[2];
      pa_in[2] = e1_ff[0] * e2_ff[1];
      pb_in[2] = e1_ff[1] * e2_ff[0];
   end

   // magnitude and sign of each component, and the degenerate flag
   always_comb begin
      sd2_in.degenerate = 1'b1;
      cd                = '0;
      cabs              = '0;
      for (int k = 0; k < LANES; k++) begin
         cd   = $signed({pa_ff[k][PW-1], pa_ff[k]}) - $signed({pb_ff[k][PW-1], pb_ff[k]});
         cabs = cd[CX-1] ? -cd : cd;
         mag_in[k]     = cabs[CM-1:0];
         sd2_in.neg[k] = cd[CX-1];
         if (cd != '0) begin
            sd2_in.degenerate = 1'b0;
         end
      end
   end

   // split squares into narrow partial products
   always_comb begin
      hpart = '0;
      lpart = '0;
      for (int k = 0; k < LANES; k++) begin
         hpart    = mag_ff[k][CM-1:LO];
         lpart    = mag_ff[k][LO-1:0];
         hh_in[k] = hpart * hpart;
         hl_in[k] = hpart * lpart;
         ll_in[k] = lpart * lpart;
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         sq_in[k] = ({{(SW-2*HI){1'b0}}, hh_ff[k]} << (2 * LO))
                  + ({{(SW-CM){1'b0}}, hl_ff[k]} << (LO + 1))
                  + {{(SW-2*LO){1'b0}}, ll_ff[k]};
      end
      s_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
      if (ld[1]) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (ld[2]) begin
         mag_ff <= mag_in;
         sd2_ff <= sd2_in;
      end
      if (ld[3]) begin
         hh_ff  <= hh_in;
         hl_ff  <= hl_in;
         ll_ff  <= ll_in;
         sd3_ff <= sd2_ff;
      end
      if (ld[4]) begin
         sq_ff  <= sq_in;
         sd4_ff <= sd3_ff;
      end
      if (ld[5]) begin
         s_ff   <= s_in;
         for (int k = 0; k < LANES; k++) begin
            c2_ff[k] <= sq_ff[k];
         end
         sd5_ff <= sd4_ff;
      end
   end

   assign up_ready = rdy[0];
   assign dn_valid = vld_ff[NSTG-1];
   assign s_out    = s_ff;
   assign c2_out   = c2_ff;
   assign side_out = sd5_ff;

   `TFN_ASSERT(a_degen_sum, clock, reset, vld_ff[NSTG-1] |-> sd5_ff.degenerate == (s_ff == '0))

endmodule

### rtl/core/tfn_div_cell.sv
`timescale 1ns / 1ps
`include "triangle_face_normal_unit_defines.svh"
module tfn_div_cell import tfn_pkg::*; #(
   parameter int SW    = 100,
   parameter int QW    = 31,
   parameter bit FIRST = 1'b0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  logic [SW-1:0]              s_in,
   input  logic [LANES-1:0][SW-1:0]   rem_in,
   input  logic [LANES-1:0][QW-1:0]   quot_in,
   input  side_type                   side_in,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output logic [SW-1:0]              s_out,
   output logic [LANES-1:0][SW-1:0]   rem_out,
   output logic [LANES-1:0][QW-1:0]   quot_out,
   output side_type                   side_out
);

   logic                     valid_ff, valid_in, load;
   logic [SW-1:0]            s_ff;
   logic [LANES-1:0][SW-1:0] rem_ff, rem_nx;
   logic [LANES-1:0][QW-1:0] quot_ff, quot_nx;
   side_type                 side_ff;
   logic [SW:0]              r2, diff;
   logic                     ge;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_ready && up_valid;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // one restoring step: double (not in the first cell), trial subtract, shift in the quotient bit
   always_comb begin
      r2   = '0;
      diff = '0;
      ge   = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         r2         = FIRST ? {1'b0, rem_in[k]} : {rem_in[k], 1'b0};
         diff       = r2 - {1'b0, s_in};
         ge         = (r2 >= {1'b0, s_in});
         rem_nx[k]  = ge ? diff[SW-1:0] : r2[SW-1:0];
         quot_nx[k] = {quot_in[k][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s_ff    <= s_in;
         rem_ff  <= rem_nx;
         quot_ff <= quot_nx;
         side_ff <= side_in;
      end
   end

   assign dn_valid = valid_ff;
   assign s_out    = s_ff;
   assign rem_out  = rem_ff;
   assign quot_out = quot_ff;
   assign side_out = side_ff;

   `TFN_ASSERT(a_hold, clock, reset, valid_ff && !dn_ready |=> valid_ff && $stable(quot_ff))
   `TFN_ASSERT(a_rem_bound, clock, reset, valid_ff && !side_ff.degenerate |-> (rem_ff[0] < s_ff) && (rem_ff[1] < s_ff) && (rem_ff[2] < s_ff))

endmodule

### rtl/core/tfn_sqrt_cell.sv
`timescale 1ns / 1ps
module tfn_sqrt_cell import tfn_pkg::*; #(
   parameter int QW  = 31,
   parameter int RW  = 16,
   parameter int BIT = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  logic [LANES-1:0][QW-1:0]  rem_in,
   input  logic [LANES-1:0][RW-1:0]  root_in,
   input  side_type                  side_in,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output logic [LANES-1:0][QW-1:0]  rem_out,
   output logic [LANES-1:0][RW-1:0]  root_out,
   output side_type                  side_out
);

   localparam int TW = QW + 2;

   logic                     valid_ff, valid_in, load;
   logic [LANES-1:0][QW-1:0] rem_ff, rem_nx;
   logic [LANES-1:0][RW-1:0] root_ff, root_nx;
   side_type                 side_ff;
   logic [TW-1:0]            trial, rem_ext, diff;
   logic                     ge;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_ready && up_valid;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // try setting this root bit: (2*root + 2^BIT) * 2^BIT against the remainder
   always_comb begin
      trial   = '0;
      rem_ext = '0;
      diff    = '0;
      ge      = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         trial      = ({{(TW-RW){1'b0}}, root_in[k]} << (BIT + 1))
                    + (TW'(1) << (2 * BIT));
         rem_ext    = {2'b00, rem_in[k]};
         diff       = rem_ext - trial;
         ge         = (rem_ext >= trial);
         rem_nx[k]  = ge ? diff[QW-1:0] : rem_in[k];
         root_nx[k] = root_in[k] | ({{(RW-1){1'b0}}, ge} << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_nx;
         root_ff <= root_nx;
         side_ff <= side_in;
      end
   end

   assign dn_valid = valid_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;

endmodule

### rtl/core/triangle_face_normal_unit.sv
// Throughput: one triangle per cycle while the output accepts; every stage is a
// registered cell with its own valid bit, so empty cells fill while a finished result
// waits at the output. The divider and square-root cell rows give one bit per cell.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
`timescale 1ns / 1ps
`include "triangle_face_normal_unit_defines.svh"
module triangle_face_normal_unit import tfn_pkg::*; #(
   parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tfn_req_if.sink    req_ch,
   tfn_rsp_if.source  rsp_ch
);

   localparam int CM = 2 * COORD_WIDTH + 1;     // cross component magnitude bits
   localparam int SW = 2 * CM + 2;              // sum of squares bits
   localparam int QW = 2 * NORMAL_FRAC_BITS + 3; // quotient c^2 * 2^(2F+2) / s
   localparam int RW = NORMAL_FRAC_BITS + 2;    // root bits, also output width
   localparam logic signed [RW-1:0] ONE_NORM = RW'(1) << NORMAL_FRAC_BITS;

   // Divider row: index 0 is the front end output, cell k drives index k+1.
   logic                     dv   [QW+1];
   logic                     drdy [QW+1];
   logic [SW-1:0]            ds   [QW+1];
   logic [LANES-1:0][SW-1:0] dr   [QW+1];
   logic [LANES-1:0][QW-1:0] dq   [QW+1];
   side_type                 dsd  [QW+1];

   // Square-root row, fed by the divider quotient.
   logic                     sv   [RW+1];
   logic                     srdy [RW+1];
   logic [LANES-1:0][QW-1:0] sr   [RW+1];
   logic [LANES-1:0][RW-1:0] sq   [RW+1];
   side_type                 ssd  [RW+1];

   logic [RW-1:0]            qmag [LANES];
   logic signed [RW-1:0]     nrm  [LANES];

   // Front end: edges, cross product, squares and their sum.
   tfn_cross #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_cross (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_ch.valid),
      .up_ready (req_ch.ready),
      .p0_x     (req_ch.p0_x),
      .p0_y     (req_ch.p0_y),
      .p0_z     (req_ch.p0_z),
      .p1_x     (req_ch.p1_x),
      .p1_y     (req_ch.p1_y),
      .p1_z     (req_ch.p1_z),
      .p2_x     (req_ch.p2_x),
      .p2_y     (req_ch.p2_y),
      .p2_z     (req_ch.p2_z),
      .dn_valid (dv[0]),
      .dn_ready (drdy[0]),
      .s_out    (ds[0]),
      .c2_out   (dr[0]),
      .side_out (dsd[0])
   );

   assign dq[0] = '0;

   // Long division of c_i^2 * 2^(2F+2) by s, one quotient bit per cell, MSB first.
   // The first cell compares without doubling: it yields the top quotient bit.
   for (genvar k = 0; k < QW; k++) begin : g_div
      tfn_div_cell #(
         .SW    (SW),
         .QW    (QW),
         .FIRST (k == 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dv[k]),
         .up_ready (drdy[k]),
         .s_in     (ds[k]),
         .rem_in   (dr[k]),
         .quot_in  (dq[k]),
         .side_in  (dsd[k]),
         .dn_valid (dv[k+1]),
         .dn_ready (drdy[k+1]),
         .s_out    (ds[k+1]),
         .rem_out  (dr[k+1]),
         .quot_out (dq[k+1]),
         .side_out (dsd[k+1])
      );
   end

   // Hand the quotient to the root row as its starting remainder.
   assign sv[0]     = dv[QW];
   assign drdy[QW]  = srdy[0];
   assign sr[0]     = dq[QW];
   assign sq[0]     = '0;
   assign ssd[0]    = dsd[QW];

   // Integer square root of the quotient, one root bit per cell, MSB first.
   for (genvar j = 0; j < RW; j++) begin : g_sqrt
      tfn_sqrt_cell #(
         .QW  (QW),
         .RW  (RW),
         .BIT (RW - 1 - j)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (sv[j]),
         .up_ready (srdy[j]),
         .rem_in   (sr[j]),
         .root_in  (sq[j]),
         .side_in  (ssd[j]),
         .dn_valid (sv[j+1]),
         .dn_ready (srdy[j+1]),
         .rem_out  (sr[j+1]),
         .root_out (sq[j+1]),
         .side_out (ssd[j+1])
      );
   end

   // The nearest q satisfies (2q-1) <= root, so q = (root + 1) / 2; apply the sign.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         qmag[k] = (sq[RW][k] + RW'(1)) >> 1;
         nrm[k]  = ssd[RW].neg[k] ? -$signed(qmag[k]) : $signed(qmag[k]);
      end
   end

   // The last root cell is the output register; drop to (1,0,0) on a flat triangle.
   assign srdy[RW]          = rsp_ch.ready;
   assign rsp_ch.valid      = sv[RW];
   assign rsp_ch.degenerate = ssd[RW].degenerate;
   assign rsp_ch.normal_x   = ssd[RW].degenerate ? ONE_NORM : nrm[0];
   assign rsp_ch.normal_y   = ssd[RW].degenerate ? '0 : nrm[1];
   assign rsp_ch.normal_z   = ssd[RW].degenerate ? '0 : nrm[2];

   `TFN_ASSERT(a_norm_range, clock, reset, rsp_ch.valid |-> (rsp_ch.normal_x <= ONE_NORM) && (rsp_ch.normal_x >= -ONE_NORM))
   `TFN_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_ch.valid)

endmodule
